[sv/rmth_pkg.sv]
// Shared types and constants for the running median block.
package rmth_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 64;
    localparam int COUNT_W  = 11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [COUNT_W-1:0]         t_count_field;

    typedef struct packed {
        t_sample sample;
        logic    start_new;
    } t_in_word;

    typedef struct packed {
        t_sample      median;
        t_sum         median_sum;
        t_count_field sample_count;
        logic         overflow;
    } t_out_word;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_sample  value;
    } t_cell_cmd;

endpackage

[sv/rmth_cell.sv]
// One cell of a descending sorted chain: holds one value, inserts or shifts toward the head.
module rmth_cell import rmth_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_occupied,
    input  logic      i_prev_keep,
    input  t_sample   i_prev_value,
    input  t_sample   i_next_value,
    output t_sample   o_value,
    output logic      o_keep
);

    t_sample r_value;
    t_sample n_value;

    // A cell keeps its value when it is occupied and not smaller than the new value.
    assign o_keep  = i_occupied && (r_value >= i_cmd.value);
    assign o_value = r_value;

    always_comb begin
        case (i_cmd.op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_INSERT: begin
                if (o_keep) begin
                    n_value = r_value;
                end else if (i_prev_keep) begin
                    n_value = i_cmd.value;
                end else begin
                    n_value = i_prev_value;
                end
            end
            CELL_SHIFT: begin
                n_value = i_next_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[sv/rmth_chain.sv]
// A row of sorted cells that acts as a max-priority queue with its largest value at the head.
module rmth_chain import rmth_pkg::*; #(
    parameter int  DEPTH  = 514,
    localparam int SIZE_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [SIZE_W-1:0] i_size,
    output t_sample           o_head
);

    t_sample w_value [DEPTH];
    logic    w_keep  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [SIZE_W-1:0] IDX = SIZE_W'(i);

        logic    w_prev_keep;
        t_sample w_prev_value;
        t_sample w_next_value;

        // The head cell always takes the new value when it cannot keep its own.
        if (i == 0) begin : g_first
            assign w_prev_keep  = 1'b1;
            assign w_prev_value = i_cmd.value;
        end else begin : g_inner
            assign w_prev_keep  = w_keep[i-1];
            assign w_prev_value = w_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_next_value = w_value[i];
        end else begin : g_body
            assign w_next_value = w_value[i+1];
        end

        rmth_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_occupied   (IDX < i_size),
            .i_prev_keep  (w_prev_keep),
            .i_prev_value (w_prev_value),
            .i_next_value (w_next_value),
            .o_value      (w_value[i]),
            .o_keep       (w_keep[i])
        );
    end

    assign o_head = w_value[0];

endmodule

[sv/running_median_two_heaps_core.sv]
// Running lower median: each accepted sample word yields one result word with the lower median
// (the ceil(n/2)-th smallest sample of the sequence), a wrapping 64-bit sum of medians and the
// sample count. The lower half sits in one sorted cell chain (largest at its head) and the upper
// half in a second chain stored bit-inverted, so its head is the smallest. Each chain has
// HEAP_DEPTH cells, and every cell compares itself with the broadcast value, so an insert or a
// removal of the head acts on all cells at once. A sample runs through accept, insert, rebalance
// and result (accept then result when dropped); result waits until the output is free. The next
// sample is taken once the sequencer is back in idle, while the previous result may still wait at
// the output. A sample is dropped with overflow set once MAX_ITEMS samples are held or the target
// half is full. No clearing pass is needed after reset: cell occupancy follows the half sizes.
module running_median_two_heaps_core import rmth_pkg::*; #(
    parameter int MAX_ITEMS  = 1024,
    parameter int HEAP_DEPTH = 514
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(HEAP_DEPTH);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_ITEMS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_BALANCE,
        ST_DONE
    } t_state;

    t_state            r_state, n_state;
    t_sample           r_sample, n_sample;
    logic              r_to_low, n_to_low;
    logic              r_drop, n_drop;
    logic [SIZE_W-1:0] r_low_size, n_low_size;
    logic [SIZE_W-1:0] r_high_size, n_high_size;
    logic [CNT_W-1:0]  r_count, n_count;
    t_sum              r_sum, n_sum;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    t_cell_cmd w_low_cmd;
    t_cell_cmd w_high_cmd;
    t_sample   w_low_head;
    t_sample   w_high_head_inv;
    t_sample   w_high_head;

    logic              w_in_acc;
    logic [SIZE_W-1:0] w_low_eff;
    logic [SIZE_W-1:0] w_high_eff;
    logic [CNT_W-1:0]  w_count_eff;
    logic              w_to_low;
    logic [SIZE_W-1:0] w_target;
    logic              w_drop;
    logic              w_high_heavy;
    logic              w_low_heavy;
    t_sample           w_median;
    t_sum              w_med_ext;
    logic              w_out_free;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    rmth_chain #(.DEPTH(HEAP_DEPTH)) u_low_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_low_cmd),
        .i_size (r_low_size),
        .o_head (w_low_head)
    );

    // The upper half is stored inverted: inverting reverses signed order exactly.
    rmth_chain #(.DEPTH(HEAP_DEPTH)) u_high_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_high_cmd),
        .i_size (r_high_size),
        .o_head (w_high_head_inv)
    );

    assign w_high_head = ~w_high_head_inv;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_low_eff   = i_in_word.start_new ? '0 : r_low_size;
    assign w_high_eff  = i_in_word.start_new ? '0 : r_high_size;
    assign w_count_eff = i_in_word.start_new ? '0 : r_count;
    assign w_to_low    = (w_low_eff == '0) || (i_in_word.sample <= w_low_head);
    assign w_target    = w_to_low ? w_low_eff : w_high_eff;
    assign w_drop      = (w_count_eff >= MAX_CNT) || (w_target >= DEPTH_SZ);

    assign w_high_heavy = {1'b0, r_high_size} > ({1'b0, r_low_size} + 1'b1);
    assign w_low_heavy  = {1'b0, r_low_size} > ({1'b0, r_high_size} + 1'b1);

    always_comb begin
        if ((r_low_size == '0) && (r_high_size == '0)) begin
            w_median = '0;
        end else if (r_low_size >= r_high_size) begin
            w_median = w_low_head;
        end else begin
            w_median = w_high_head;
        end
    end

    assign w_med_ext   = {{(SUM_W - SAMPLE_W){w_median[SAMPLE_W-1]}}, w_median};
    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};

    always_comb begin
        w_low_cmd.op     = CELL_HOLD;
        w_low_cmd.value  = r_sample;
        w_high_cmd.op    = CELL_HOLD;
        w_high_cmd.value = ~r_sample;
        case (r_state)
            ST_INSERT: begin
                if (r_to_low) begin
                    w_low_cmd.op = CELL_INSERT;
                end else begin
                    w_high_cmd.op = CELL_INSERT;
                end
            end
            ST_BALANCE: begin
                // Move the head of the heavier half into the other half.
                if (w_high_heavy) begin
                    w_high_cmd.op   = CELL_SHIFT;
                    w_low_cmd.op    = CELL_INSERT;
                    w_low_cmd.value = w_high_head;
                end else if (w_low_heavy) begin
                    w_low_cmd.op     = CELL_SHIFT;
                    w_high_cmd.op    = CELL_INSERT;
                    w_high_cmd.value = ~w_low_head;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_to_low    = r_to_low;
        n_drop      = r_drop;
        n_low_size  = r_low_size;
        n_high_size = r_high_size;
        n_count     = r_count;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_sample    = i_in_word.sample;
                    n_to_low    = w_to_low;
                    n_drop      = w_drop;
                    n_low_size  = w_low_eff;
                    n_high_size = w_high_eff;
                    n_count     = w_count_eff;
                    if (i_in_word.start_new) begin
                        n_sum = '0;
                    end
                    n_state = w_drop ? ST_DONE : ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (r_to_low) begin
                    n_low_size = r_low_size + 1'b1;
                end else begin
                    n_high_size = r_high_size + 1'b1;
                end
                n_count = r_count + 1'b1;
                n_state = ST_BALANCE;
            end
            ST_BALANCE: begin
                if (w_high_heavy) begin
                    n_high_size = r_high_size - 1'b1;
                    n_low_size  = r_low_size + 1'b1;
                end else if (w_low_heavy) begin
                    n_low_size  = r_low_size - 1'b1;
                    n_high_size = r_high_size + 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    if (!r_drop) begin
                        n_sum = r_sum + w_med_ext;
                    end
                    n_out_valid             = 1'b1;
                    n_out_word.median       = w_median;
                    n_out_word.median_sum   = r_drop ? r_sum : (r_sum + w_med_ext);
                    n_out_word.sample_count = w_count_ext[COUNT_W-1:0];
                    n_out_word.overflow     = r_drop;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_low_size  <= '0;
            r_high_size <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low_size  <= n_low_size;
            r_high_size <= n_high_size;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_sample   <= n_sample;
        r_to_low   <= n_to_low;
        r_drop     <= n_drop;
        r_out_word <= n_out_word;
    end

endmodule

[sv/rmth_check.sv]
// Port-level checks for the running median block, bound to the top level.
module rmth_check import rmth_pkg::*; #(
    parameter int MAX_ITEMS = 1024
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    logic         w_out_acc;
    logic         r_have_last, n_have_last;
    t_sum         r_last_sum, n_last_sum;
    t_count_field r_last_count, n_last_count;

    assign w_out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_have_last  = r_have_last || w_out_acc;
        n_last_sum   = w_out_acc ? o_out_word.median_sum : r_last_sum;
        n_last_count = w_out_acc ? o_out_word.sample_count : r_last_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last  <= 1'b0;
            r_last_sum   <= '0;
            r_last_count <= '0;
        end else begin
            r_have_last  <= n_have_last;
            r_last_sum   <= n_last_sum;
            r_last_count <= n_last_count;
        end
    end

    // A result word waiting at the output holds still.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // The engine works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an accepted word");

    // A dropped sample leaves the sum and the count as they were.
    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_out_word.overflow && r_have_last |->
            (o_out_word.median_sum == r_last_sum) &&
            (o_out_word.sample_count == r_last_count))
        else $error("dropped sample changed the state");

    // A taken sample either starts a sequence or advances the count by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !o_out_word.overflow |->
            (o_out_word.sample_count == t_count_field'(1)) ||
            (r_have_last && (o_out_word.sample_count == r_last_count + 1'b1)))
        else $error("sample count did not advance by one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (MAX_ITEMS > 2047) ||
            (int'(o_out_word.sample_count) <= MAX_ITEMS))
        else $error("sample count beyond capacity");

endmodule

bind running_median_two_heaps_core rmth_check #(.MAX_ITEMS(MAX_ITEMS)) u_rmth_check (.*);

[tb/tb.sv]
// Testbench for running_median_two_heaps_core: predicted result words checked against the block.
`timescale 1ns / 1ps

module tb;
    import rmth_pkg::*;

    localparam int MAX_ITEMS   = 1024;
    localparam int HEAP_DEPTH  = 514;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_ITEMS = 400;

    localparam t_sample SAMPLE_MIN = 32'sh8000_0000;
    localparam t_sample SAMPLE_MAX = 32'sh7fff_ffff;

    typedef enum int {
        VALS_FULL,
        VALS_NARROW,
        VALS_EXTREME,
        VALS_MIXED
    } t_value_class;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    running_median_two_heaps_core #(
        .MAX_ITEMS (MAX_ITEMS),
        .HEAP_DEPTH(HEAP_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: all samples of the sequence in ascending order. The lower half is the
    // first low_count entries, the upper half the rest, which matches the two heaps since
    // every lower-half value is no larger than any upper-half value.
    t_sample   sorted_samples[$];
    int        low_count = 0;
    int        high_count = 0;
    int        held_samples = 0;
    t_sum      median_total = '0;
    t_out_word pending_medians[$];

    int mismatches = 0;
    int burst_left = 0;
    int hold_requests = 0;

    function automatic t_sample current_lower_median();
        if (low_count == 0 && high_count == 0)
            return '0;
        if (low_count >= high_count)
            return sorted_samples[low_count-1];
        return sorted_samples[low_count];
    endfunction

    function automatic t_out_word predict_median_word(input t_in_word w);
        t_out_word r;
        logic      to_low;
        logic      dropped;
        int        pos;
        if (w.start_new) begin
            sorted_samples.delete();
            low_count    = 0;
            high_count   = 0;
            held_samples = 0;
            median_total = '0;
        end
        if (low_count == 0)
            to_low = 1'b1;
        else
            to_low = (w.sample <= sorted_samples[low_count-1]);
        dropped = (held_samples >= MAX_ITEMS) ||
                  ((to_low ? low_count : high_count) >= HEAP_DEPTH);
        if (!dropped) begin
            pos = 0;
            while (pos < sorted_samples.size() && sorted_samples[pos] <= w.sample)
                pos++;
            sorted_samples.insert(pos, w.sample);
            if (to_low)
                low_count++;
            else
                high_count++;
            // Moving a heap top across only shifts the boundary between the halves.
            if (high_count > low_count + 1) begin
                high_count--;
                low_count++;
            end else if (low_count > high_count + 1) begin
                low_count--;
                high_count++;
            end
            held_samples++;
            median_total = median_total + t_sum'(current_lower_median());
        end
        r.median       = current_lower_median();
        r.median_sum   = median_total;
        r.sample_count = t_count_field'(held_samples);
        r.overflow     = dropped;
        return r;
    endfunction

    function automatic t_sample rand_sample(input t_value_class cls);
        t_value_class c;
        c = cls;
        if (c == VALS_MIXED)
            c = t_value_class'($urandom_range(0, 2));
        case (c)
            VALS_NARROW: return $signed($urandom_range(0, 6)) - 3;
            VALS_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return '0;
                    3: return -1;
                    4: return SAMPLE_MIN + 1;
                    default: return SAMPLE_MAX - 1;
                endcase
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Offers one sample word, with the sender working in bursts separated by gaps.
    task automatic send_word(input t_sample s, input logic start);
        t_in_word w;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
        w.sample    = s;
        w.start_new = start;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        burst_left--;
        pending_medians.push_back(predict_median_word(w));
    endtask

    // Result checker.
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: median %0d sum %0d count %0d ovf %0b",
                             o_out_word.median, o_out_word.median_sum,
                             o_out_word.sample_count, o_out_word.overflow);
            end else begin
                want = pending_medians.pop_front();
                if (want.median !== o_out_word.median ||
                    want.median_sum !== o_out_word.median_sum ||
                    want.sample_count !== o_out_word.sample_count ||
                    want.overflow !== o_out_word.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 want.median, want.median_sum, want.sample_count,
                                 want.overflow, o_out_word.median, o_out_word.median_sum,
                                 o_out_word.sample_count, o_out_word.overflow);
                end
            end
        end
    end

    // Receiver: switches among stall patterns, and honors long hold-off requests.
    int         hold_seen = 0;
    int         hold_left = 0;
    int         ready_mode = 0;
    int         mode_left = 0;
    logic [3:0] ready_phase = '0;

    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 1'b1;
        if (hold_seen != hold_requests) begin
            hold_seen   <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ready_phase[2];
            endcase
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        // The first sequence after reset runs without a start flag.
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word(3, 1'b0);
        send_word(7, 1'b0);
        send_word(SAMPLE_MIN, 1'b1);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b1);
        send_word(SAMPLE_MIN, 1'b0);
        // Equal samples land on the lower half.
        send_word(-1, 1'b1);
        send_word(-1, 1'b0);
        send_word(-1, 1'b0);
        send_word(0, 1'b0);
        send_word(1, 1'b0);
        send_word(-2, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX - 1, 1'b1);
    endtask

    // Fills one sequence past its capacity so that later samples are dropped.
    task automatic test_capacity();
        t_value_class cls;
        cls = t_value_class'($urandom_range(0, 3));
        send_word(rand_sample(cls), 1'b1);
        repeat (MAX_ITEMS - 1 + 12)
            send_word(rand_sample(cls), 1'b0);
        send_word(rand_sample(VALS_EXTREME), 1'b1);
        send_word(rand_sample(VALS_FULL), 1'b0);
    endtask

    // The receiver holds off while words keep coming, so the block fills and stalls.
    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        burst_left = 200;
        send_word(rand_sample(VALS_MIXED), 1'b1);
        repeat (40)
            send_word(rand_sample(VALS_MIXED), 1'b0);
    endtask

    task automatic test_random_sequences();
        int           sent;
        int           seq_len;
        t_value_class cls;
        logic         start;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: seq_len = $urandom_range(25, 90);
                5: seq_len = $urandom_range(100, 220);
                default: seq_len = $urandom_range(1, 24);
            endcase
            cls = t_value_class'($urandom_range(0, 3));
            for (int k = 0; k < seq_len; k++) begin
                // Mostly well-formed sequences; now and then a stray start or a missing one.
                if (k == 0)
                    start = ($urandom_range(0, 9) != 0);
                else
                    start = ($urandom_range(0, 39) == 0);
                send_word(rand_sample(cls), start);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random_sequences();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
sv/rmth_pkg.sv
sv/rmth_cell.sv
sv/rmth_chain.sv
sv/running_median_two_heaps_core.sv
sv/rmth_check.sv
tb/tb.sv
